FILE: sv/v2p_pkg.sv
// ----------------------------------------------------------------------------
// v2p_pkg: shared types and constants for the v210 to 4:2:0 planar converter
// Register indexes, stream packing offsets and reciprocal constants.
// ----------------------------------------------------------------------------
package v2p_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 13'd1920;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 13'd1080;
  localparam logic [CFG_DATA_W-1:0] MAX_LINES    = 13'd4096;

  // x / 6 = (x * RECIP6) >> RECIP6_SHIFT, exact for x below 2^17
  localparam logic [31:0] RECIP6       = 32'd43691;
  localparam int          RECIP6_SHIFT = 18;
  // y / 3 = (y * RECIP3) >> RECIP3_SHIFT, exact for y below 2048
  localparam logic [31:0] RECIP3       = 32'd683;
  localparam int          RECIP3_SHIFT = 11;

  // stream widths
  localparam int IN_W   = 128;
  localparam int OUT_W  = 104;
  localparam int USER_W = 1;

  // output tdata field offsets
  localparam int LUMA_LSB  = 0;
  localparam int CB_LSB    = 48;
  localparam int CR_LSB    = 72;
  localparam int CNT_LSB   = 96;
  localparam int FEND_BIT  = 99;

  // one group in flight between the input stage and the output register
  typedef struct packed {
    logic [47:0] luma;
    logic [23:0] cb;
    logic [23:0] cr;
    logic [2:0]  cnt;
    logic        odd;
    logic        last_line;
    logic        lend;
  } grp_t;

endpackage

FILE: sv/v2p_ram.sv
// ----------------------------------------------------------------------------
// v2p_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds while
// the read enable is low.
// ----------------------------------------------------------------------------
module v2p_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 683
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/v210_to_420p_converter.sv
// ----------------------------------------------------------------------------
// v210_to_420p_converter: v210 groups in, 8-bit planar 4:2:0 groups out
// Luma is cut to 8 bits; chroma of even lines goes to a line store and is
// averaged into the chroma of the odd line that follows.
//
//   channel  dir  width  transfer                 contents
//   in_      in   128    in_tvalid & in_tready    one v210 group
//   out_     out  104    out_tvalid & out_tready  6 luma, 3 Cb, 3 Cr, flags
//   cfg_     in   4+13   cfg_valid & cfg_ready    frame_width, frame_height
//
// One group per cycle unless the output stalls; a result is registered in s1 and then in the output register.
// The line store is one memory: even lines write it, odd lines read it at
// the same group position a whole line later, so accesses never overlap.
// Reset (rst_n low, synchronous) clears position, line and valid flags; the
// store needs no clearing. A stalled output holds one result and one more in
// flight, then in_tready drops. Padding groups transfer with no result.
// ----------------------------------------------------------------------------
module v210_to_420p_converter #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // word_a 31:0, word_b 63:32, word_c 95:64, word_d 127:96
  input  logic [v2p_pkg::IN_W-1:0]         in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // luma_bytes 47:0, cb_bytes 71:48, cr_bytes 95:72, pixel_count 98:96,
  // frame_end 99, zero 103:100
  output logic [v2p_pkg::OUT_W-1:0]        out_tdata,
  // chroma_valid 0
  output logic [v2p_pkg::USER_W-1:0]       out_tuser,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [v2p_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [v2p_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int STORE_DEPTH = (MAX_WIDTH + 5) / 6;
  localparam int PITCH_MAX   = ((MAX_WIDTH + 47) / 48) * 8;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int AVW = $clog2(STORE_DEPTH + 1);
  localparam int PW  = $clog2(PITCH_MAX + 1);
  localparam int GW  = $clog2(PITCH_MAX);
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int RST_W      = (1920 > MAX_WIDTH) ? MAX_WIDTH : 1920;
  localparam int RST_ACTIVE = (RST_W + 5) / 6;
  localparam int RST_PITCH  = ((RST_W + 47) / 48) * 8;

  // configuration, held as effective values
  logic [WW-1:0]                  width_r, width_nxt;
  logic [AVW-1:0]                 active_r, active_nxt;
  logic [PW-1:0]                  pitch_r, pitch_nxt;
  logic [v2p_pkg::CFG_DATA_W-1:0] height_r, height_nxt;

  logic [v2p_pkg::CFG_DATA_W-1:0] w_even;
  logic [WW-1:0]                  w_sat;
  logic [v2p_pkg::CFG_DATA_W-1:0] h_sat;
  logic [31:0]                    act_prod;
  logic [31:0]                    pitch_grp;
  logic [31:0]                    pitch_prod;
  logic                           cfg_wr;

  // position state
  logic [GW-1:0]  grp_r, grp_nxt;
  logic [11:0]    line_r, line_nxt;

  // pipeline
  logic                 s1_valid_r, s1_valid_nxt;
  v2p_pkg::grp_t        s1_r, s1_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [v2p_pkg::OUT_W-1:0] out_data_r, out_data_nxt;
  logic                 out_cv_r, out_cv_nxt;
  logic                 out_lend_r, out_lend_nxt;

  logic           accept;
  logic           out_free;
  logic           s1_adv;
  logic [PW-1:0]  grp_inc;
  logic [12:0]    line_inc;
  logic           act_grp;
  logic           last_line;
  logic           odd;
  logic [WW:0]    left;
  logic [2:0]     cnt;
  logic [31:0]    wa, wb, wc, wd;
  logic [23:0]    cb_raw, cr_raw;
  logic [47:0]    st_rdata;

  logic [23:0]    cb_fin, cr_fin;
  logic [47:0]    lmask;
  logic [23:0]    cmask;
  logic [8:0]     sum_cb [3];
  logic [8:0]     sum_cr [3];

  // --------------------------------------------------------------------------
  // configuration: clamp and derive group counts at write time
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_comb begin
    w_even = cfg_data & ~13'd1;
    if (w_even < 13'd2) begin
      w_sat = WW'(2);
    end else if (32'(w_even) > MAX_WIDTH) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(w_even);
    end
    if (cfg_data == '0) begin
      h_sat = 13'd1;
    end else if (cfg_data > v2p_pkg::MAX_LINES) begin
      h_sat = v2p_pkg::MAX_LINES;
    end else begin
      h_sat = cfg_data;
    end
    act_prod   = (32'(w_sat) + 32'd5) * v2p_pkg::RECIP6;
    pitch_grp  = (32'(w_sat) + 32'd47) >> 4;
    pitch_prod = (pitch_grp * v2p_pkg::RECIP3) >> v2p_pkg::RECIP3_SHIFT;
  end

  always_comb begin
    width_nxt  = width_r;
    active_nxt = active_r;
    pitch_nxt  = pitch_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        v2p_pkg::REG_FRAME_WIDTH: begin
          width_nxt  = w_sat;
          active_nxt = AVW'(act_prod >> v2p_pkg::RECIP6_SHIFT);
          pitch_nxt  = PW'(pitch_prod << 3);
        end
        v2p_pkg::REG_FRAME_HEIGHT: begin
          height_nxt = h_sat;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input stage: position, counts, byte extraction
  // --------------------------------------------------------------------------
  assign out_free  = ~out_valid_r | out_tready;
  assign s1_adv    = s1_valid_r & out_free;
  assign in_tready = ~s1_valid_r | out_free;
  assign accept    = in_tvalid & in_tready;

  assign wa = in_tdata[31:0];
  assign wb = in_tdata[63:32];
  assign wc = in_tdata[95:64];
  assign wd = in_tdata[127:96];

  assign grp_inc   = PW'(grp_r) + PW'(1);
  assign line_inc  = {1'b0, line_r} + 13'd1;
  assign act_grp   = PW'(grp_r) < PW'(active_r);
  assign last_line = line_inc >= height_r;
  assign odd       = line_r[0];
  assign left      = {1'b0, width_r} - ((WW+1)'({grp_r, 2'b00}) + (WW+1)'({grp_r, 1'b0}));
  assign cnt       = (left >= (WW+1)'(6)) ? 3'd6 : left[2:0];
  assign cb_raw    = {wc[29:22], wb[19:12], wa[9:2]};
  assign cr_raw    = {wd[19:12], wc[9:2], wa[29:22]};

  always_comb begin
    s1_nxt           = s1_r;
    s1_valid_nxt     = s1_valid_r & ~s1_adv;
    if (accept && act_grp) begin
      s1_valid_nxt     = 1'b1;
      s1_nxt.luma      = {wd[29:22], wd[9:2], wc[19:12], wb[29:22], wb[9:2], wa[19:12]};
      s1_nxt.cb        = cb_raw;
      s1_nxt.cr        = cr_raw;
      s1_nxt.cnt       = cnt;
      s1_nxt.odd       = odd;
      s1_nxt.last_line = last_line;
      s1_nxt.lend      = grp_inc == PW'(active_r);
    end
  end

  // advance position; wrap at the pitch
  always_comb begin
    grp_nxt  = grp_r;
    line_nxt = line_r;
    if (accept) begin
      if (grp_inc >= pitch_r) begin
        grp_nxt  = '0;
        line_nxt = last_line ? 12'd0 : line_inc[11:0];
      end else begin
        grp_nxt  = grp_inc[GW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // chroma line store: even lines write, odd lines read
  // --------------------------------------------------------------------------
  v2p_ram #(
    .WIDTH (48),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept & act_grp & ~odd),
    .waddr (grp_r[AW-1:0]),
    .wdata ({cr_raw, cb_raw}),
    .re    (accept & act_grp & odd),
    .raddr (grp_r[AW-1:0]),
    .rdata (st_rdata)
  );

  // --------------------------------------------------------------------------
  // second stage: average, mask, load output register
  // --------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_cb[k] = {1'b0, s1_r.cb[8*k +: 8]} + {1'b0, st_rdata[8*k +: 8]};
      sum_cr[k] = {1'b0, s1_r.cr[8*k +: 8]} + {1'b0, st_rdata[24 + 8*k +: 8]};
    end
    if (s1_r.odd) begin
      cb_fin = {sum_cb[2][8:1], sum_cb[1][8:1], sum_cb[0][8:1]};
      cr_fin = {sum_cr[2][8:1], sum_cr[1][8:1], sum_cr[0][8:1]};
    end else if (s1_r.last_line) begin
      cb_fin = s1_r.cb;
      cr_fin = s1_r.cr;
    end else begin
      cb_fin = '0;
      cr_fin = '0;
    end
    case (s1_r.cnt)
      3'd2: begin
        lmask = 48'h0000_0000_ffff;
        cmask = 24'h0000ff;
      end
      3'd4: begin
        lmask = 48'h0000_ffff_ffff;
        cmask = 24'h00ffff;
      end
      default: begin
        lmask = 48'hffff_ffff_ffff;
        cmask = 24'hffffff;
      end
    endcase
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_cv_nxt    = out_cv_r;
    out_lend_nxt  = out_lend_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'd0,
                       s1_r.lend & s1_r.last_line,
                       s1_r.cnt,
                       cr_fin & cmask,
                       cb_fin & cmask,
                       s1_r.luma & lmask};
      out_cv_nxt    = s1_r.odd | s1_r.last_line;
      out_lend_nxt  = s1_r.lend;
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WW'(RST_W);
      active_r    <= AVW'(RST_ACTIVE);
      pitch_r     <= PW'(RST_PITCH);
      height_r    <= v2p_pkg::RESET_HEIGHT;
      grp_r       <= '0;
      line_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      active_r    <= active_nxt;
      pitch_r     <= pitch_nxt;
      height_r    <= height_nxt;
      grp_r       <= grp_nxt;
      line_r      <= line_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload holds without reset
  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_data_r <= out_data_nxt;
    out_cv_r   <= out_cv_nxt;
    out_lend_r <= out_lend_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cv_r;
  assign out_tlast  = out_lend_r;

endmodule

FILE: sv/v2p_checker.sv
// ----------------------------------------------------------------------------
// v2p_checker: port-level checks for the v210 to 4:2:0 converter
// Watches the result channel over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module v2p_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic [v2p_pkg::OUT_W-1:0]     out_tdata,
  input logic [v2p_pkg::USER_W-1:0]    out_tuser,
  input logic                          out_tlast,
  input logic                          out_tvalid,
  input logic                          out_tready
);

  logic [2:0] pix_cnt;
  logic       fend;

  assign pix_cnt = out_tdata[v2p_pkg::CNT_LSB +: 3];
  assign fend    = out_tdata[v2p_pkg::FEND_BIT];

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // pixel count is always a whole number of pairs
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pix_cnt == 3'd2 || pix_cnt == 3'd4 || pix_cnt == 3'd6))
    else $error("bad pixel count");

  // partial group only at the end of a line
  a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && pix_cnt != 3'd6 |-> out_tlast)
    else $error("partial group not at line end");

  // frame end falls on a line end that carries final chroma
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && fend |-> out_tlast && out_tuser[0])
    else $error("frame end without line end or final chroma");

endmodule

bind v210_to_420p_converter v2p_checker u_v2p_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

FILE: verif/v210_to_420p_checker.sv
// ----------------------------------------------------------------------------
// v210_to_420p_checker: result predictor and comparator for the converter
// Watches the register, input and result channels. Each input transfer is
// turned into the planar group it should produce, using a private copy of
// the chroma line store and raster position. Each result transfer is
// compared with the oldest predicted group.
// ----------------------------------------------------------------------------
module v210_to_420p_checker #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [v2p_pkg::IN_W-1:0]         in_tdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [v2p_pkg::OUT_W-1:0]        out_tdata,
  input  logic [v2p_pkg::USER_W-1:0]       out_tuser,
  input  logic                             out_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [v2p_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [v2p_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               mismatches,
  output int                               pending,
  output int                               checked
);
  import v2p_pkg::*;

  localparam int STORE_DEPTH = (MAX_WIDTH + 5) / 6;

  typedef struct packed {
    logic [3:0]  spare;
    logic        frame_end;
    logic        line_end;
    logic        chroma_valid;
    logic [2:0]  count;
    logic [23:0] cr;
    logic [23:0] cb;
    logic [47:0] luma;
  } planar_group_t;

  planar_group_t              planar_groups[$];
  logic [47:0]                chroma_store [0:STORE_DEPTH-1];
  logic [CFG_DATA_W-1:0]      width_reg;
  logic [CFG_DATA_W-1:0]      height_reg;
  int unsigned                group_pos;
  int unsigned                line_num;
  int                         error_count;
  int                         match_count;

  function automatic logic [7:0] mean8(logic [7:0] x, logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[8:1];
  endfunction

  // Turn one v210 group into its planar group and advance the raster
  task automatic convert_group(input logic [IN_W-1:0] grp);
    logic [31:0]   a, b, c, d;
    logic [47:0]   lmask, kept;
    logic [23:0]   cb, cr, cmask;
    int unsigned   ew, eh, active, pitch, left, cnt;
    bit            last_line, odd;
    planar_group_t r;
    a = grp[31:0];
    b = grp[63:32];
    c = grp[95:64];
    d = grp[127:96];
    ew = width_reg & 13'h1ffe;
    if (ew < 2) ew = 2;
    if (ew > MAX_WIDTH) ew = MAX_WIDTH;
    eh = height_reg;
    if (eh < 1) eh = 1;
    if (eh > MAX_LINES) eh = MAX_LINES;
    active = (ew + 5) / 6;
    pitch = ((ew + 47) / 48) * 8;
    last_line = (line_num + 1) >= eh;
    odd = line_num[0];
    if (group_pos < active) begin
      left = ew - 6 * group_pos;
      cnt = (left < 6) ? left : 6;
      r = '0;
      r.luma = {d[29:22], d[9:2], c[19:12], b[29:22], b[9:2], a[19:12]};
      cb = {c[29:22], b[19:12], a[9:2]};
      cr = {d[19:12], c[9:2], a[29:22]};
      lmask = (cnt >= 6) ? '1 : (48'd1 << (8 * cnt)) - 48'd1;
      cmask = (cnt >= 6) ? '1 : (24'd1 << (4 * cnt)) - 24'd1;
      if (odd) begin
        // blend with the even line above
        kept = chroma_store[group_pos];
        for (int k = 0; k < 3; k++) begin
          cb[8*k +: 8] = mean8(cb[8*k +: 8], kept[8*k +: 8]);
          cr[8*k +: 8] = mean8(cr[8*k +: 8], kept[24 + 8*k +: 8]);
        end
        r.chroma_valid = 1'b1;
      end else begin
        // hold chroma for the next line; only a closing even line emits it
        chroma_store[group_pos] = {cr, cb};
        r.chroma_valid = last_line;
        if (!last_line) begin
          cb = '0;
          cr = '0;
        end
      end
      r.luma = r.luma & lmask;
      r.cb = cb & cmask;
      r.cr = cr & cmask;
      r.count = cnt[2:0];
      r.line_end = (group_pos + 1) == active;
      r.frame_end = r.line_end && last_line;
      planar_groups.push_back(r);
    end
    if (group_pos + 1 >= pitch) begin
      group_pos = 0;
      line_num = last_line ? 0 : line_num + 1;
    end else begin
      group_pos = group_pos + 1;
    end
  endtask

  always @(posedge clk) begin
    planar_group_t got, want;
    if (!rst_n) begin
      planar_groups.delete();
      for (int i = 0; i < STORE_DEPTH; i++) chroma_store[i] = '0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      group_pos = 0;
      line_num = 0;
      error_count = 0;
      match_count = 0;
    end else begin
      // register writes land before the next group
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH: width_reg = cfg_data;
          REG_FRAME_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      // compare each result transfer with the oldest prediction
      if (out_tvalid && out_tready) begin
        got.spare = out_tdata[OUT_W-1:FEND_BIT+1];
        got.frame_end = out_tdata[FEND_BIT];
        got.line_end = out_tlast;
        got.chroma_valid = out_tuser[0];
        got.count = out_tdata[CNT_LSB +: 3];
        got.cr = out_tdata[CR_LSB +: 24];
        got.cb = out_tdata[CB_LSB +: 24];
        got.luma = out_tdata[LUMA_LSB +: 48];
        if (planar_groups.size() == 0) begin
          error_count++;
          $display("%0t: result with none pending: luma=%h cb=%h cr=%h", $time,
                   got.luma, got.cb, got.cr);
        end else begin
          want = planar_groups.pop_front();
          match_count++;
          if (got !== want) begin
            error_count++;
            $display("%0t: expected luma=%h cb=%h cr=%h cnt=%0d cv=%b le=%b fe=%b sp=%h",
                     $time, want.luma, want.cb, want.cr, want.count,
                     want.chroma_valid, want.line_end, want.frame_end, want.spare);
            $display("%0t: actual   luma=%h cb=%h cr=%h cnt=%0d cv=%b le=%b fe=%b sp=%h",
                     $time, got.luma, got.cb, got.cr, got.count,
                     got.chroma_valid, got.line_end, got.frame_end, got.spare);
          end
        end
      end
      if (in_tvalid && in_tready) convert_group(in_tdata);
    end
    mismatches <= error_count;
    pending <= planar_groups.size();
    checked <= match_count;
  end

endmodule

FILE: verif/v210_to_420p_converter_test.sv
// ----------------------------------------------------------------------------
// v210_to_420p_converter_test: stream test of the v210 to 4:2:0 converter
// Drives v210 groups and register writes with random gaps and output
// stalls. A short directed frame covers blending, a partial last group and
// a raw closing line; random phases then vary width and height, including
// saturating values, a full 4096-pixel line and changes inside a frame.
// ----------------------------------------------------------------------------
module v210_to_420p_converter_test;
  import v2p_pkg::*;

  localparam int ITEM_TARGET   = 1850;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 22;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hf;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic [USER_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    fails;
  int                    outstanding;
  int                    results_checked;
  int unsigned           idle_pct = IDLE_PCT;
  int unsigned           stall_pct = IDLE_PCT;
  int unsigned           cycle_count = 0;
  int unsigned           sent = 0;
  int unsigned           reg_writes = 0;
  int unsigned           frames_done = 0;
  // raster position as the block should see it
  logic [CFG_DATA_W-1:0] width_reg = RESET_WIDTH;
  logic [CFG_DATA_W-1:0] height_reg = RESET_HEIGHT;
  int unsigned           col = 0;
  int unsigned           row = 0;

  v210_to_420p_converter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  v210_to_420p_checker planar_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (fails),
    .pending    (outstanding),
    .checked    (results_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // random output stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("v210_to_420p_converter_test NOT OK");
      $finish;
    end
  end

  function automatic int unsigned eff_width(logic [CFG_DATA_W-1:0] w);
    int unsigned v;
    v = w & 13'h1ffe;
    if (v < 2) v = 2;
    if (v > 4096) v = 4096;
    return v;
  endfunction

  function automatic int unsigned line_pitch(logic [CFG_DATA_W-1:0] w);
    return ((eff_width(w) + 47) / 48) * 8;
  endfunction

  // mostly random words, with saturated and empty words mixed in
  function automatic logic [IN_W-1:0] random_group();
    logic [IN_W-1:0] g;
    int unsigned     r;
    for (int k = 0; k < 4; k++) begin
      r = $urandom_range(99);
      g[32*k +: 32] = (r < 6) ? 32'hffff_ffff : (r < 10) ? 32'h0 : $urandom;
    end
    return g;
  endfunction

  // Offer one group, wait for its transfer, then advance the raster
  task automatic send_group(input logic [IN_W-1:0] grp);
    int unsigned h;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= grp;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_LINES) h = MAX_LINES;
    if (col + 1 >= line_pitch(width_reg)) begin
      col = 0;
      if (row + 1 >= h) begin
        row = 0;
        frames_done++;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
  endtask

  // Drop valid and wait until every predicted result has drained
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else if (idx == REG_FRAME_HEIGHT) height_reg = val;
  endtask

  initial begin
    int unsigned           phase_no, n_lines, total;
    logic [CFG_DATA_W-1:0] next_w, next_h;
    logic [IN_W-1:0]       grp;
    bit                    big_line, big_done;
    phase_no = 0;
    big_done = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first group under reset settings, then shrink mid-line to a
    // two-group line with a partial second group; three lines close a frame
    send_group({4{32'hffff_ffff}});
    quiesce();
    write_reg(REG_FRAME_WIDTH, 13'd9);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_UNUSED, '1);
    while (!(col == 0 && row == 0)) begin
      // word_d in the top bits, word_a in the bottom
      if (col == 0) grp = {4{32'hffff_ffff}};
      else if (col == 1 && row != 1) grp = {32'h5555_5555, 32'haaaa_aaaa, 32'h0, 32'hffff_ffff};
      else if (col == 1) grp = '0;
      else grp = random_group();
      send_group(grp);
    end

    // random phases: each drains, reprograms and runs lines of groups
    while (sent < ITEM_TARGET) begin
      quiesce();
      phase_no++;
      if (sent >= 700 && sent < 1000) begin
        idle_pct = 0;
        stall_pct = 0;
      end else begin
        idle_pct = IDLE_PCT;
        stall_pct = IDLE_PCT;
      end
      big_line = !big_done && phase_no >= 6 && col == 0 && !row[0];
      if (big_line) begin
        next_w = '1;
        next_h = 13'd4096;
        big_done = 1;
      end else if (phase_no == 2) begin
        next_w = '0;
        next_h = '1;
      end else if (phase_no == 3) begin
        next_w = 13'd1;
        next_h = '0;
      end else begin
        next_w = ($urandom_range(99) < 75) ? CFG_DATA_W'($urandom_range(96, 2))
                                           : CFG_DATA_W'($urandom_range(400, 97));
        next_h = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(8191, 0))
                                          : CFG_DATA_W'($urandom_range(7, 1));
      end
      // an odd line reads what the even line above stored: widen only at
      // the start of an even line
      if ((eff_width(next_w) + 5) / 6 <= (eff_width(width_reg) + 5) / 6
          || (col == 0 && !row[0]))
        write_reg(REG_FRAME_WIDTH, next_w);
      write_reg(REG_FRAME_HEIGHT, next_h);
      total = (col >= line_pitch(width_reg)) ? 1 : line_pitch(width_reg) - col;
      if (!big_line) begin
        n_lines = (line_pitch(width_reg) >= 200) ? 0 : $urandom_range(4);
        total += n_lines * line_pitch(width_reg);
        if ($urandom_range(3) == 0) total += $urandom_range(line_pitch(width_reg) - 1, 1);
      end
      repeat (total) send_group(random_group());
    end

    quiesce();
    $display("Sent %0d v210 groups, checked %0d planar results, %0d register writes.",
             sent, results_checked, reg_writes);
    $display("Closed %0d frames; full 4096-pixel line %s.", frames_done,
             big_done ? "covered" : "not reached");
    if (fails == 0) begin
      $display("v210_to_420p_converter_test OK");
    end else begin
      $display("v210_to_420p_converter_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/v2p_pkg.sv
sv/v2p_ram.sv
sv/v210_to_420p_converter.sv
sv/v2p_checker.sv
verif/v210_to_420p_checker.sv
verif/v210_to_420p_converter_test.sv
